// ===== sv/ppsl_pkg.sv =====
// ----------------------------------------------------------------------------
// ppsl_pkg
// Types, widths, register codes and the arctangent table shared by the
// polar pose steering law pipeline.
// ----------------------------------------------------------------------------
package ppsl_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int POS_WIDTH_DEF     = 16;

  // field widths
  localparam int IN_POS_W  = 16;
  localparam int ANGLE_W   = 16;
  localparam int GAIN_W    = 16;
  localparam int DIST_W    = 17;
  localparam int SPEED_W   = 15;

  // offset magnitude never exceeds 65535
  localparam int DX_W       = 17;
  localparam int MAG_W      = DX_W - 1;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int RAD_W      = SQ_W + 2;
  localparam int SQRT_STEPS = RAD_W / 2;
  localparam int ROOT_W     = SQRT_STEPS;
  localparam int REM_W      = ROOT_W + 2;

  // rotator vector carries the offset scaled by 2^16 plus growth headroom
  localparam int FRAC_W   = 16;
  localparam int XY_W     = DX_W + FRAC_W + 3;
  localparam int Z_W      = 32;
  localparam int ATAN_LEN = 24;

  localparam logic [Z_W-1:0] ATAN_TAB [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = GAIN_W;

  localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BEARING_GAIN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FINAL_ANGLE_GAIN = 2'd2;

  localparam logic [GAIN_W-1:0] SPEED_GAIN_RST       = 16'h0100;
  localparam logic [GAIN_W-1:0] BEARING_GAIN_RST     = 16'h0200;
  localparam logic [GAIN_W-1:0] FINAL_ANGLE_GAIN_RST = 16'hFF80;

  typedef struct packed {
    logic signed [IN_POS_W-1:0] cur_x;
    logic signed [IN_POS_W-1:0] cur_y;
    logic signed [ANGLE_W-1:0]  cur_heading;
    logic signed [IN_POS_W-1:0] goal_x;
    logic signed [IN_POS_W-1:0] goal_y;
  } item_t;

  typedef struct packed {
    logic [DIST_W-1:0]         distance;
    logic signed [ANGLE_W-1:0] bearing_error;
    logic signed [ANGLE_W-1:0] final_angle;
    logic [SPEED_W-1:0]        speed_cmd;
    logic signed [ANGLE_W-1:0] turn_cmd;
    logic                      saturated;
  } result_t;

  typedef struct packed {
    logic [GAIN_W-1:0]        speed_gain;
    logic signed [GAIN_W-1:0] bearing_gain;
    logic signed [GAIN_W-1:0] final_angle_gain;
  } gains_t;

  // state handed from cell to cell
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [Z_W-1:0]         z;
    logic [REM_W-1:0]       rem;
    logic [ROOT_W-1:0]      root;
    logic [RAD_W-1:0]       rad;
    logic                   zero;
    logic [ANGLE_W-1:0]     head;
  } cell_data_t;

endpackage

// ===== sv/ppsl_front.sv =====
// ----------------------------------------------------------------------------
// ppsl_front
// Input capture, goal offset, squared distance and quadrant pre-rotation.
// ----------------------------------------------------------------------------
module ppsl_front #(
  parameter int POS_WIDTH = ppsl_pkg::POS_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ppsl_pkg::item_t      in_data,
  output logic                 out_valid,
  output ppsl_pkg::cell_data_t out_data,
  input  logic                 down_en
);
  import ppsl_pkg::*;

  localparam int SRC_W    = (POS_WIDTH < IN_POS_W) ? POS_WIDTH : IN_POS_W;
  localparam bit SIGN_EXT = (POS_WIDTH <= IN_POS_W);

  localparam logic [Z_W-1:0] Z_QUARTER_POS = 32'h40000000;
  localparam logic [Z_W-1:0] Z_QUARTER_NEG = 32'hC0000000;

  function automatic logic signed [DX_W-1:0] ext_pos(input logic [IN_POS_W-1:0] f);
    logic signed [DX_W-1:0] p;
    p = '0;
    for (int b = 0; b < DX_W; b++) begin
      if (b < SRC_W) begin
        p[b] = f[b];
      end else begin
        p[b] = SIGN_EXT ? f[SRC_W-1] : 1'b0;
      end
    end
    return p;
  endfunction

  // stage 0: offset
  logic                     v0_r;
  logic signed [DX_W-1:0]   dx0_r, dy0_r, dx0_nxt, dy0_nxt;
  logic [ANGLE_W-1:0]       head0_r;
  // stage 1: squares and pre-rotation
  logic                     v1_r;
  logic [SQ_W-1:0]          sqx1_r, sqy1_r, sqx1_nxt, sqy1_nxt;
  logic signed [XY_W-1:0]   x1_r, y1_r, x1_nxt, y1_nxt;
  logic [Z_W-1:0]           z1_r, z1_nxt;
  logic                     zero1_r;
  logic [ANGLE_W-1:0]       head1_r;
  // stage 2: radicand
  logic                     v2_r;
  cell_data_t               d2_r, d2_nxt;

  logic                     en0, en1, en2;
  logic signed [DX_W-1:0]   adx, ady;
  logic [MAG_W-1:0]         mag_x, mag_y;
  logic signed [XY_W-1:0]   xs, ys;

  assign en2      = !v2_r || down_en;
  assign en1      = !v1_r || en2;
  assign en0      = !v0_r || en1;
  assign in_ready = en0;

  assign dx0_nxt = ext_pos(in_data.goal_x) - ext_pos(in_data.cur_x);
  assign dy0_nxt = ext_pos(in_data.goal_y) - ext_pos(in_data.cur_y);

  always_comb begin
    adx      = dx0_r[DX_W-1] ? -dx0_r : dx0_r;
    ady      = dy0_r[DX_W-1] ? -dy0_r : dy0_r;
    mag_x    = adx[MAG_W-1:0];
    mag_y    = ady[MAG_W-1:0];
    sqx1_nxt = mag_x * mag_x;
    sqy1_nxt = mag_y * mag_y;
    xs = {{(XY_W-DX_W-FRAC_W){dx0_r[DX_W-1]}}, dx0_r, {FRAC_W{1'b0}}};
    ys = {{(XY_W-DX_W-FRAC_W){dy0_r[DX_W-1]}}, dy0_r, {FRAC_W{1'b0}}};
    x1_nxt = xs;
    y1_nxt = ys;
    z1_nxt = '0;
    if (dx0_r[DX_W-1]) begin
      if (!dy0_r[DX_W-1]) begin
        x1_nxt = ys;
        y1_nxt = -xs;
        z1_nxt = Z_QUARTER_POS;
      end else begin
        x1_nxt = -ys;
        y1_nxt = xs;
        z1_nxt = Z_QUARTER_NEG;
      end
    end
  end

  always_comb begin
    d2_nxt      = '0;
    d2_nxt.x    = x1_r;
    d2_nxt.y    = y1_r;
    d2_nxt.z    = z1_r;
    d2_nxt.rad  = RAD_W'(sqx1_r) + RAD_W'(sqy1_r);
    d2_nxt.zero = zero1_r;
    d2_nxt.head = head1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en0) v0_r <= in_valid;
      if (en1) v1_r <= v0_r;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en0 && in_valid) begin
      dx0_r   <= dx0_nxt;
      dy0_r   <= dy0_nxt;
      head0_r <= in_data.cur_heading;
    end
    if (en1 && v0_r) begin
      sqx1_r  <= sqx1_nxt;
      sqy1_r  <= sqy1_nxt;
      x1_r    <= x1_nxt;
      y1_r    <= y1_nxt;
      z1_r    <= z1_nxt;
      zero1_r <= (dx0_r == '0) && (dy0_r == '0);
      head1_r <= head0_r;
    end
    if (en2 && v1_r) begin
      d2_r <= d2_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_data  = d2_r;

endmodule

// ===== sv/ppsl_cell.sv =====
// ----------------------------------------------------------------------------
// ppsl_cell
// One link of the chain: a vectoring rotation step, one root digit, or both, as STEP selects.
// ----------------------------------------------------------------------------
module ppsl_cell #(
  parameter int STEP          = 0,
  parameter int CORDIC_STAGES = ppsl_pkg::CORDIC_STAGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  input  ppsl_pkg::cell_data_t up_data,
  output logic                 en_up,
  output logic                 out_valid,
  output ppsl_pkg::cell_data_t out_data,
  input  logic                 down_en
);
  import ppsl_pkg::*;

  localparam bit DO_ROT  = (STEP < CORDIC_STAGES) && (STEP < ATAN_LEN);
  localparam bit DO_SQRT = (STEP < SQRT_STEPS);
  localparam int TAB_IDX = (STEP < ATAN_LEN) ? STEP : 0;
  localparam logic [Z_W-1:0] ATAN_STEP = ATAN_TAB[TAB_IDX];

  logic                   v_r;
  cell_data_t             d_r, d_nxt;
  logic signed [XY_W-1:0] xs, ys;
  logic                   y_pos;
  logic [REM_W+1:0]       trial_src, trial;
  logic                   ge;

  assign en_up = !v_r || down_en;

  always_comb begin
    d_nxt     = up_data;
    xs        = $signed(up_data.x) >>> STEP;
    ys        = $signed(up_data.y) >>> STEP;
    y_pos     = !up_data.y[XY_W-1] && (up_data.y != '0);
    trial_src = {up_data.rem, up_data.rad[RAD_W-1 -: 2]};
    trial     = (REM_W + 2)'({up_data.root, 2'b01});
    ge        = trial_src >= trial;
    if (DO_ROT) begin
      if (y_pos) begin
        d_nxt.x = up_data.x + ys;
        d_nxt.y = up_data.y - xs;
        d_nxt.z = up_data.z + ATAN_STEP;
      end else begin
        d_nxt.x = up_data.x - ys;
        d_nxt.y = up_data.y + xs;
        d_nxt.z = up_data.z - ATAN_STEP;
      end
    end
    if (DO_SQRT) begin
      d_nxt.rem  = ge ? REM_W'(trial_src - trial) : trial_src[REM_W-1:0];
      d_nxt.root = {up_data.root[ROOT_W-2:0], ge};
      d_nxt.rad  = {up_data.rad[RAD_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en_up) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_up && up_valid) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = d_r;

endmodule

// ===== sv/ppsl_back.sv =====
// ----------------------------------------------------------------------------
// ppsl_back
// Angle rounding, bearing and final angle, gain products, saturation and
// the output register.
// ----------------------------------------------------------------------------
module ppsl_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  input  ppsl_pkg::cell_data_t up_data,
  output logic                 en_up,
  input  ppsl_pkg::gains_t     gains,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ppsl_pkg::result_t    out_data
);
  import ppsl_pkg::*;

  localparam int SPD_PROD_W = GAIN_W + DIST_W;
  localparam int SPD_W      = SPD_PROD_W - 8;
  localparam int PROD_W     = 2 * GAIN_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int TURN_W     = SUM_W - 8;
  localparam logic [Z_W-1:0] Z_ROUND = 32'h00008000;
  localparam logic signed [TURN_W-1:0] TURN_MAX = TURN_W'(32767);
  localparam logic signed [TURN_W-1:0] TURN_MIN = -TURN_W'(32768);

  // stage 0
  logic                      v0_r;
  logic signed [ANGLE_W-1:0] alpha0_r, beta0_r, alpha0_nxt, beta0_nxt;
  logic [DIST_W-1:0]         dist0_r;
  logic [SPD_PROD_W-1:0]     spd0_r, spd0_nxt;
  logic [Z_W-1:0]            z_rnd;
  logic [ANGLE_W-1:0]        theta;
  // stage 1
  logic                      v1_r;
  logic signed [PROD_W-1:0]  pa1_r, pb1_r, pa1_nxt, pb1_nxt;
  logic [SPEED_W-1:0]        spd1_r;
  logic                      ssat1_r;
  logic signed [ANGLE_W-1:0] alpha1_r, beta1_r;
  logic [DIST_W-1:0]         dist1_r;
  logic [SPD_W-1:0]          spd_shift;
  logic                      ssat1_nxt;
  // stage 2
  logic                      v2_r;
  result_t                   res_r, res_nxt;
  logic signed [SUM_W-1:0]   sum;
  logic signed [TURN_W-1:0]  turn;
  logic                      tsat;

  logic                      en0, en1, en2;

  assign en2   = !v2_r || out_ready;
  assign en1   = !v1_r || en2;
  assign en0   = !v0_r || en1;
  assign en_up = en0;

  always_comb begin
    z_rnd      = up_data.z + Z_ROUND;
    theta      = up_data.zero ? '0 : z_rnd[Z_W-1 -: ANGLE_W];
    alpha0_nxt = theta - up_data.head;
    beta0_nxt  = ANGLE_W'(0) - up_data.head - alpha0_nxt;
    spd0_nxt   = SPD_PROD_W'(gains.speed_gain) * SPD_PROD_W'(up_data.root);
  end

  always_comb begin
    pa1_nxt   = gains.bearing_gain * alpha0_r;
    pb1_nxt   = gains.final_angle_gain * beta0_r;
    spd_shift = spd0_r[SPD_PROD_W-1:8];
    ssat1_nxt = |spd_shift[SPD_W-1:SPEED_W];
  end

  always_comb begin
    sum  = {pa1_r[PROD_W-1], pa1_r} + {pb1_r[PROD_W-1], pb1_r};
    turn = sum[SUM_W-1:8];
    tsat = (turn > TURN_MAX) || (turn < TURN_MIN);
    res_nxt.distance      = dist1_r;
    res_nxt.bearing_error = alpha1_r;
    res_nxt.final_angle   = beta1_r;
    res_nxt.speed_cmd     = spd1_r;
    if (turn > TURN_MAX) begin
      res_nxt.turn_cmd = TURN_MAX[ANGLE_W-1:0];
    end else if (turn < TURN_MIN) begin
      res_nxt.turn_cmd = TURN_MIN[ANGLE_W-1:0];
    end else begin
      res_nxt.turn_cmd = turn[ANGLE_W-1:0];
    end
    res_nxt.saturated = ssat1_r || tsat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en0) v0_r <= up_valid;
      if (en1) v1_r <= v0_r;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en0 && up_valid) begin
      alpha0_r <= alpha0_nxt;
      beta0_r  <= beta0_nxt;
      dist0_r  <= up_data.root;
      spd0_r   <= spd0_nxt;
    end
    if (en1 && v0_r) begin
      pa1_r    <= pa1_nxt;
      pb1_r    <= pb1_nxt;
      spd1_r   <= ssat1_nxt ? {SPEED_W{1'b1}} : spd_shift[SPEED_W-1:0];
      ssat1_r  <= ssat1_nxt;
      alpha1_r <= alpha0_r;
      beta1_r  <= beta0_r;
      dist1_r  <= dist0_r;
    end
    if (en2 && v1_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_data  = res_r;

endmodule

// ===== sv/polar_pose_steering_law.sv =====
// One transaction per cycle sustained while out_ready is high.
// The depth is set by the cell chain: each cell does one rotation step, one root digit or both.
// Backpressure stalls only the stages that hold data; bubbles still take input.
// Reset: synchronous active-low rst_n empties the pipeline and sets the gains to
//   speed 1.0, bearing 2.0, final angle -0.5 (Q8.8).
// ----------------------------------------------------------------------------
// polar_pose_steering_law
// Polar-coordinate steering law for a unicycle robot: distance, bearing
// error, final angle and saturated speed and turn commands.
// ----------------------------------------------------------------------------
module polar_pose_steering_law #(
  parameter int CORDIC_STAGES = ppsl_pkg::CORDIC_STAGES_DEF,
  parameter int POS_WIDTH     = ppsl_pkg::POS_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ppsl_pkg::item_t                   in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ppsl_pkg::result_t                 out_data,
  input  logic                              cfg_we,
  input  logic [ppsl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ppsl_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ppsl_pkg::*;

  localparam int N_CELLS = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;

  gains_t     gains_r;
  logic       cv   [N_CELLS+1];
  cell_data_t cdat [N_CELLS+1];
  logic       cen  [N_CELLS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r.speed_gain       <= SPEED_GAIN_RST;
      gains_r.bearing_gain     <= BEARING_GAIN_RST;
      gains_r.final_angle_gain <= FINAL_ANGLE_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SPEED_GAIN:       gains_r.speed_gain       <= cfg_data;
        REG_BEARING_GAIN:     gains_r.bearing_gain     <= cfg_data;
        REG_FINAL_ANGLE_GAIN: gains_r.final_angle_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  ppsl_front #(
    .POS_WIDTH (POS_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (cv[0]),
    .out_data  (cdat[0]),
    .down_en   (cen[0])
  );

  for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
    ppsl_cell #(
      .STEP          (k),
      .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .up_valid  (cv[k]),
      .up_data   (cdat[k]),
      .en_up     (cen[k]),
      .out_valid (cv[k+1]),
      .out_data  (cdat[k+1]),
      .down_en   (cen[k+1])
    );
  end

  ppsl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (cv[N_CELLS]),
    .up_data   (cdat[N_CELLS]),
    .en_up     (cen[N_CELLS]),
    .gains     (gains_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== sv/ppsl_checker.sv =====
// ----------------------------------------------------------------------------
// ppsl_checker
// Port-level checks on the steering law block, bound to the top level.
// ----------------------------------------------------------------------------
module ppsl_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input ppsl_pkg::result_t out_data
);
  import ppsl_pkg::*;

  // reset leaves an empty pipeline that takes input
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // with no result pending every stage can advance
  a_no_dead_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // saturation flag only with a clipped command
  a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      (out_data.speed_cmd == 15'h7fff) || (out_data.turn_cmd == 16'sh7fff) ||
      (out_data.turn_cmd == 16'sh8000))
    else $error("saturated set without a clipped command");

  // zero offset gives zero angle and zero speed
  a_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.distance == '0) |->
      (out_data.final_angle == '0) && (out_data.speed_cmd == '0))
    else $error("zero offset gave nonzero final angle or speed");

endmodule

bind polar_pose_steering_law ppsl_checker u_ppsl_checker (.*);
